/* sv/pdts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCI device table search: shared types and constants
// Command codes, entry layout, request, response and row structures.
// ----------------------------------------------------------------------------
package pdts_pkg;
    localparam int DefTableDepth = 64;
    localparam logic [15:0] DropMax = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  cls;
        logic [7:0]  sub;
    } t_entry;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  bus_number;
        logic [4:0]  slot_number;
        logic [2:0]  function_number;
        logic [15:0] vendor_id;
        logic [15:0] device_id;
        logic [7:0]  class_code;
        logic [7:0]  subclass_code;
        logic [5:0]  ordinal;
        logic [3:0]  any_mask;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [5:0]  entry_index;
        logic [7:0]  hit_bus;
        logic [4:0]  hit_slot;
        logic [2:0]  hit_function;
        logic [15:0] hit_vendor;
        logic [15:0] hit_device;
        logic [7:0]  hit_class;
        logic [7:0]  hit_subclass;
        logic [6:0]  entry_count;
        logic [15:0] dropped_count;
    } t_rsp;

    // query travelling down the row
    typedef struct packed {
        logic        valid;
        logic        search;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  cls;
        logic [7:0]  sub;
        logic [5:0]  ord;
        logic [3:0]  mask;
    } t_query;

    // hit state travelling down the row beside the query
    typedef struct packed {
        logic        found;
        logic [8:0]  seen;
        logic [8:0]  idx;
        t_entry      entry;
    } t_hit;
endpackage
`default_nettype wire

/* sv/pdts_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCI device table search: word channels
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface pdts_req_if;
    logic          valid;
    logic          ready;
    pdts_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdts_rsp_if;
    logic          valid;
    logic          ready;
    pdts_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/pdts_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCI device table search: table cell
// Holds one entry, compares the passing query and hands it on.
// ----------------------------------------------------------------------------
module pdts_cell #(
    parameter int Index = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire pdts_pkg::t_entry i_wr_entry,
    input  wire logic             i_live,
    input  wire pdts_pkg::t_query i_query,
    input  wire pdts_pkg::t_hit   i_hit,
    output pdts_pkg::t_query      o_query,
    output pdts_pkg::t_hit        o_hit
);
    import pdts_pkg::*;

    t_entry r_entry;
    t_query r_query;
    t_hit   r_hit;
    t_hit   n_hit;
    logic   w_match;

    always_comb begin
        if (i_query.search) begin
            w_match = (i_query.mask[0] || r_entry.cls == i_query.cls) &&
                      (i_query.mask[1] || r_entry.sub == i_query.sub) &&
                      (i_query.mask[2] || r_entry.vendor == i_query.vendor) &&
                      (i_query.mask[3] || r_entry.device == i_query.device);
        end else begin
            w_match = r_entry.bus == i_query.bus && r_entry.slot == i_query.slot &&
                      r_entry.func == i_query.func;
        end
        n_hit = i_hit;
        if (i_live && !i_hit.found && w_match) begin
            if (!i_query.search || i_hit.seen == {3'd0, i_query.ord}) begin
                n_hit.found = 1'b1;
                n_hit.idx   = 9'(Index);
                n_hit.entry = r_entry;
            end else begin
                n_hit.seen = i_hit.seen + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_wr_entry;
        end
        r_hit <= n_hit;
        if (!i_rst_n) begin
            r_query.valid <= 1'b0;
        end else begin
            r_query <= i_query;
        end
    end

    assign o_query = r_query;
    assign o_hit   = r_hit;
endmodule
`default_nettype wire

/* sv/pci_device_table_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCI device table search: top level
// Table of bus functions searched by a row of entry cells.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Clear and insert present their response
// in the cycle after the request is accepted. Search and lookup send the query
// down the row of TABLE_DEPTH cells, one cell per cycle, and present their
// response once the query has passed the last cell. The response is held in an
// output register until it is taken, and the next request is accepted in the
// cycle after that.
module pci_device_table_search #(
    parameter int TABLE_DEPTH = pdts_pkg::DefTableDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdts_req_if.sink   i_req,
    pdts_rsp_if.source o_rsp
);
    import pdts_pkg::*;

    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_count;
    logic [15:0]     r_drop;
    t_rsp            r_rsp;
    t_rsp            n_rsp;
    t_query          w_q   [TABLE_DEPTH+1];
    t_hit            w_h   [TABLE_DEPTH+1];
    t_entry          w_new;
    logic            w_acc;
    logic            w_full;

    assign i_req.ready = r_state == ST_IDLE;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = r_count >= CntW'(TABLE_DEPTH);
    assign w_new       = '{bus: i_req.data.bus_number, slot: i_req.data.slot_number,
                           func: i_req.data.function_number,
                           vendor: i_req.data.vendor_id, device: i_req.data.device_id,
                           cls: i_req.data.class_code, sub: i_req.data.subclass_code};

    always_comb begin
        w_q[0]        = '0;
        w_q[0].valid  = w_acc && (i_req.data.command == CMD_SEARCH ||
                                  i_req.data.command == CMD_LOOKUP);
        w_q[0].search = i_req.data.command == CMD_SEARCH;
        w_q[0].bus    = i_req.data.bus_number;
        w_q[0].slot   = i_req.data.slot_number;
        w_q[0].func   = i_req.data.function_number;
        w_q[0].vendor = i_req.data.vendor_id;
        w_q[0].device = i_req.data.device_id;
        w_q[0].cls    = i_req.data.class_code;
        w_q[0].sub    = i_req.data.subclass_code;
        w_q[0].ord    = i_req.data.ordinal;
        w_q[0].mask   = i_req.data.any_mask;
        w_h[0]        = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pdts_cell #(.Index(g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (w_acc && i_req.data.command == CMD_INSERT && !w_full &&
                        r_count[IdxW-1:0] == IdxW'(g)),
            .i_wr_entry(w_new),
            .i_live    (r_count > CntW'(g)),
            .i_query   (w_q[g]),
            .i_hit     (w_h[g]),
            .o_query   (w_q[g+1]),
            .o_hit     (w_h[g+1])
        );
    end

    always_comb begin
        n_rsp               = '0;
        n_rsp.entry_count   = 7'(r_count);
        n_rsp.dropped_count = r_drop;
        if (r_state == ST_SCAN) begin
            n_rsp.found        = w_h[TABLE_DEPTH].found;
            n_rsp.entry_index  = w_h[TABLE_DEPTH].found ?
                                 6'(w_h[TABLE_DEPTH].idx) : 6'd0;
            n_rsp.hit_bus      = w_h[TABLE_DEPTH].entry.bus;
            n_rsp.hit_slot     = w_h[TABLE_DEPTH].entry.slot;
            n_rsp.hit_function = w_h[TABLE_DEPTH].entry.func;
            n_rsp.hit_vendor   = w_h[TABLE_DEPTH].entry.vendor;
            n_rsp.hit_device   = w_h[TABLE_DEPTH].entry.device;
            n_rsp.hit_class    = w_h[TABLE_DEPTH].entry.cls;
            n_rsp.hit_subclass = w_h[TABLE_DEPTH].entry.sub;
        end else if (i_req.data.command == CMD_CLEAR) begin
            n_rsp.entry_count   = 7'd0;
            n_rsp.dropped_count = 16'd0;
        end else if (i_req.data.command == CMD_INSERT) begin
            if (w_full) begin
                if (r_drop != DropMax) begin
                    n_rsp.dropped_count = r_drop + 16'd1;
                end
            end else begin
                n_rsp.entry_count  = 7'(r_count + CntW'(1));
                n_rsp.found        = 1'b1;
                n_rsp.entry_index  = 6'(r_count);
                n_rsp.hit_bus      = w_new.bus;
                n_rsp.hit_slot     = w_new.slot;
                n_rsp.hit_function = w_new.func;
                n_rsp.hit_vendor   = w_new.vendor;
                n_rsp.hit_device   = w_new.device;
                n_rsp.hit_class    = w_new.cls;
                n_rsp.hit_subclass = w_new.sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_drop  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_rsp <= n_rsp;
                        unique case (i_req.data.command)
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_drop  <= '0;
                                r_state <= ST_OUT;
                            end
                            CMD_INSERT: begin
                                if (w_full) begin
                                    if (r_drop != DropMax) begin
                                        r_drop <= r_drop + 16'd1;
                                    end
                                end else begin
                                    r_count <= r_count + CntW'(1);
                                end
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_SCAN;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_q[TABLE_DEPTH].valid) begin
                        r_rsp   <= n_rsp;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_state == ST_OUT;
    assign o_rsp.data  = r_rsp;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TABLE_DEPTH)) else $error("count over depth");
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_q[TABLE_DEPTH].valid) |=> r_state == ST_OUT)
        else $error("scan did not finish");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !r_rsp.found) |-> r_rsp.entry_index == 6'd0)
        else $error("miss with index");
    a_drop_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_drop) == DropMax && r_drop != DropMax) |-> r_drop == 16'd0)
        else $error("drop count wrapped");
`endif
endmodule
`default_nettype wire

/* dv/tb_pci_device_table_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI device table search: testbench
// Drives command words with random gaps and back-pressure, predicts each
// response from a local copy of the table and compares every field.
// ----------------------------------------------------------------------------
module tb_pci_device_table_search;
    import pdts_pkg::*;

    localparam int Depth = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pdts_req_if req_ch ();
    pdts_rsp_if rsp_ch ();

    pci_device_table_search #(.TABLE_DEPTH(Depth)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    t_entry      table_copy [Depth];
    int          held_count;
    logic [15:0] refused;

    t_req pending_words [$];
    t_rsp expected_rsp [$];
    int   mismatches;
    int   stim_done;
    int   hold_off;
    logic req_taken;

    // pool of positions, ids and class codes so that searches and lookups hit
    logic [15:0] pos_pool [8];
    logic [31:0] id_pool [8];
    logic [15:0] cc_pool [4];

    function automatic t_rsp predict_table(t_req w);
        t_rsp r;
        int seen;
        r = '0;
        case (w.command)
            CMD_CLEAR: begin
                held_count = 0;
                refused = 16'd0;
            end
            CMD_INSERT: begin
                if (held_count >= Depth) begin
                    if (refused != DropMax) refused = refused + 16'd1;
                end else begin
                    table_copy[held_count] = '{w.bus_number, w.slot_number,
                        w.function_number, w.vendor_id, w.device_id,
                        w.class_code, w.subclass_code};
                    r.found = 1'b1;
                    r.entry_index = 6'(held_count);
                    held_count++;
                end
            end
            CMD_SEARCH: begin
                seen = 0;
                for (int i = 0; i < held_count; i++) begin
                    t_entry e;
                    e = table_copy[i];
                    if ((w.any_mask[0] || e.cls == w.class_code) &&
                        (w.any_mask[1] || e.sub == w.subclass_code) &&
                        (w.any_mask[2] || e.vendor == w.vendor_id) &&
                        (w.any_mask[3] || e.device == w.device_id)) begin
                        if (seen == int'(w.ordinal)) begin
                            r.found = 1'b1;
                            r.entry_index = 6'(i);
                            break;
                        end
                        seen++;
                    end
                end
            end
            default: begin
                for (int i = 0; i < held_count; i++) begin
                    if (table_copy[i].bus == w.bus_number &&
                        table_copy[i].slot == w.slot_number &&
                        table_copy[i].func == w.function_number) begin
                        r.found = 1'b1;
                        r.entry_index = 6'(i);
                        break;
                    end
                end
            end
        endcase
        if (r.found) begin
            t_entry e;
            e = table_copy[r.entry_index];
            r.hit_bus = e.bus;
            r.hit_slot = e.slot;
            r.hit_function = e.func;
            r.hit_vendor = e.vendor;
            r.hit_device = e.device;
            r.hit_class = e.cls;
            r.hit_subclass = e.sub;
        end
        r.entry_count = 7'(held_count);
        r.dropped_count = refused;
        return r;
    endfunction

    function automatic t_req random_word(t_cmd c, bit pooled);
        t_req w;
        w.command = c;
        w.bus_number = 8'($urandom);
        w.slot_number = 5'($urandom);
        w.function_number = 3'($urandom);
        w.vendor_id = 16'($urandom);
        w.device_id = 16'($urandom);
        w.class_code = 8'($urandom);
        w.subclass_code = 8'($urandom);
        w.ordinal = 6'($urandom);
        w.any_mask = 4'($urandom);
        if (pooled) begin
            {w.bus_number, w.slot_number, w.function_number} =
                pos_pool[$urandom_range(7)];
            {w.vendor_id, w.device_id} = id_pool[$urandom_range(7)];
            {w.class_code, w.subclass_code} = cc_pool[$urandom_range(3)];
            if ($urandom_range(3) != 0) w.ordinal = 6'($urandom_range(5));
        end
        return w;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(9) < 5) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(80, 20);
        return $urandom_range(3);
    endfunction

    // driver
    int   send_gap;
    t_req cur_word;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end else if (req_ch.valid && !req_taken) begin
            // hold
        end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            cur_word = pending_words.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.data <= cur_word;
            send_gap = gap_len();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // receiver ready
    int recv_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            recv_gap = gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(predict_table(req_ch.data));
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", rsp_ch.data);
            end else begin
                t_rsp e;
                e = expected_rsp.pop_front();
                if (rsp_ch.data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, rsp_ch.data);
                end
            end
        end
    end

    initial begin
        t_req w;
        mismatches = 0;
        stim_done = 0;
        hold_off = 0;
        send_gap = 0;
        recv_gap = 0;
        held_count = 0;
        refused = 16'd0;
        req_taken = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        foreach (pos_pool[i]) pos_pool[i] = 16'($urandom);
        foreach (id_pool[i]) id_pool[i] = $urandom;
        foreach (cc_pool[i]) cc_pool[i] = 16'($urandom);
        id_pool[0] = 32'h0000_FFFF;
        id_pool[1] = 32'hFFFF_0000;
        pos_pool[0] = 16'h0000;
        pos_pool[1] = 16'hFFFF;
        cc_pool[0] = 16'h00FF;
        cc_pool[1] = 16'hFF00;

        // directed: empty table, extremes, duplicates, wildcards
        pending_words.push_back(random_word(CMD_SEARCH, 0));
        pending_words.push_back(random_word(CMD_LOOKUP, 0));
        w = '0;
        w.command = CMD_INSERT;
        pending_words.push_back(w);
        w = '1;
        w.command = CMD_INSERT;
        pending_words.push_back(w);
        pending_words.push_back(w);
        w.command = CMD_LOOKUP;
        pending_words.push_back(w);
        w.command = CMD_SEARCH;
        w.ordinal = 6'd1;
        w.any_mask = 4'd0;
        pending_words.push_back(w);
        w.ordinal = 6'd2;
        w.any_mask = 4'hF;
        pending_words.push_back(w);
        w.ordinal = 6'd63;
        pending_words.push_back(w);
        w = '0;
        w.command = CMD_LOOKUP;
        pending_words.push_back(w);
        w.command = CMD_SEARCH;
        pending_words.push_back(w);
        w.command = CMD_CLEAR;
        pending_words.push_back(w);
        w.command = CMD_LOOKUP;
        pending_words.push_back(w);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // random: mostly table builds with queries; some fill past full
        for (int n = 0; n < 1760; n++) begin
            int k;
            k = $urandom_range(99);
            if (k < 2) pending_words.push_back(random_word(CMD_CLEAR, 0));
            else if (k < 40) pending_words.push_back(random_word(CMD_INSERT, 1));
            else if (k < 65) pending_words.push_back(random_word(CMD_SEARCH, 1));
            else if (k < 85) pending_words.push_back(random_word(CMD_LOOKUP, 1));
            else pending_words.push_back(random_word(t_cmd'($urandom_range(3, 1)), 0));
            if (n == 600) begin
                // overfill to reach the dropped counter
                for (int j = 0; j < 80; j++)
                    pending_words.push_back(random_word(CMD_INSERT, 1));
            end
        end

        // long receiver hold-off while words keep coming
        wait (pending_words.size() < 1500);
        @(negedge i_clk);
        hold_off = 1;
        repeat (400) @(negedge i_clk);
        hold_off = 0;

        wait (pending_words.size() == 0 && !req_ch.valid);
        wait (expected_rsp.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
